// ===== rtl/bankers_safety_allocator_defines.svh =====
// Assertion macros shared by the allocator's checker.
// Depends on nothing; expects clk and rst in the including scope.
`ifndef BANKERS_SAFETY_ALLOCATOR_DEFINES_SVH
`define BANKERS_SAFETY_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bsa_pkg.sv =====
// Shared types and codes of the Banker's safety allocator.
// Used by the controller, the datapath, the top level and the checker.
package bsa_pkg;

  localparam int AMT_W    = 8;
  localparam int IN_LANES = 4;
  localparam int PID_W    = 3;

  typedef enum logic [1:0] {
    FN_LOAD_AVAIL = 2'd0,
    FN_LOAD_ROW   = 2'd1,
    FN_REQUEST    = 2'd2,
    FN_CHECK      = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_OVER_NEED   = 3'd1,
    ST_WAIT        = 3'd2,
    ST_WAIT_UNSAFE = 3'd3,
    ST_BAD_ROW     = 3'd4,
    ST_UNSAFE      = 3'd5
  } status_t;

  typedef struct packed {
    logic capture;
    logic wr_avail;
    logic wr_row;
    logic grant;
    logic undo;
    logic chk_init;
    logic chk_step;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  pid_bad;
    logic  row_bad;
    logic  over_need;
    logic  short_avail;
    logic  chk_end;
    logic  chk_safe;
  } sts_t;

endpackage

// ===== rtl/bsa_ctrl.sv =====
// Controller of the Banker's safety allocator: sequences decode, table
// updates, safety scans and rollback, and holds the result register. Uses bsa_pkg.
module bsa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output bsa_pkg::status_t out_status,
  output logic            out_safe,
  output bsa_pkg::cmd_t   cmd,
  input  bsa_pkg::sts_t   sts
);
  import bsa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_INIT   = 6'b000100,
    S_SCAN   = 6'b001000,
    S_UNDO   = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t  state, state_next;
  status_t status, status_next;
  logic    grant_mode, grant_mode_next;
  logic    check_mode, check_mode_next;
  logic    safe, safe_next;
  logic    out_valid, out_valid_next;
  status_t out_status_next;
  logic    out_safe_next;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    state_next      = state;
    status_next     = status;
    grant_mode_next = grant_mode;
    check_mode_next = check_mode;
    safe_next       = safe;
    out_valid_next  = out_valid && !m_tready;
    out_status_next = out_status;
    out_safe_next   = out_safe;
    cmd             = '0;
    cmd.capture     = s_tvalid && s_tready;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DECODE;
      end
      S_DECODE: begin
        status_next     = ST_OK;
        grant_mode_next = 1'b0;
        check_mode_next = 1'b0;
        unique case (sts.func)
          FN_LOAD_AVAIL: cmd.wr_avail = 1'b1;
          FN_LOAD_ROW: begin
            if (sts.pid_bad || sts.row_bad) status_next = ST_BAD_ROW;
            else cmd.wr_row = 1'b1;
          end
          FN_REQUEST: begin
            priority if (sts.pid_bad) status_next = ST_BAD_ROW;
            else if (sts.over_need) status_next = ST_OVER_NEED;
            else if (sts.short_avail) status_next = ST_WAIT;
            else begin
              cmd.grant       = 1'b1;
              grant_mode_next = 1'b1;
            end
          end
          FN_CHECK: check_mode_next = 1'b1;
          default: ;
        endcase
        state_next = S_INIT;
      end
      S_INIT: begin
        cmd.chk_init = 1'b1;
        state_next   = S_SCAN;
      end
      S_SCAN: begin
        cmd.chk_step = 1'b1;
        if (sts.chk_end) begin
          if (grant_mode && !sts.chk_safe) begin
            status_next     = ST_WAIT_UNSAFE;
            grant_mode_next = 1'b0;
            state_next      = S_UNDO;
          end else begin
            safe_next = sts.chk_safe;
            if (check_mode && !sts.chk_safe) status_next = ST_UNSAFE;
            state_next = S_RESP;
          end
        end
      end
      S_UNDO: begin
        cmd.undo   = 1'b1;
        state_next = S_INIT;
      end
      S_RESP: begin
        if (!out_valid || m_tready) begin
          out_valid_next  = 1'b1;
          out_status_next = status;
          out_safe_next   = safe;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      status     <= ST_OK;
      grant_mode <= 1'b0;
      check_mode <= 1'b0;
      safe       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      status     <= status_next;
      grant_mode <= grant_mode_next;
      check_mode <= check_mode_next;
      safe       <= safe_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_status <= out_status_next;
    out_safe   <= out_safe_next;
  end

endmodule

// ===== rtl/bsa_dpath.sv =====
// Datapath of the Banker's safety allocator: item registers, available,
// allocation and need tables, and the row-serial safety scanner. Uses bsa_pkg.
module bsa_dpath #(
  parameter int PROCESSES  = 8,
  parameter int RESOURCES  = 4,
  parameter int COUNT_BITS = 8
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  bsa_pkg::func_t                                   func,
  input  logic [bsa_pkg::PID_W-1:0]                        proc_id,
  input  logic [bsa_pkg::IN_LANES-1:0][bsa_pkg::AMT_W-1:0] amount,
  input  logic [bsa_pkg::IN_LANES-1:0][bsa_pkg::AMT_W-1:0] held,
  input  bsa_pkg::cmd_t                                    cmd,
  output bsa_pkg::sts_t                                    sts
);
  import bsa_pkg::*;

  localparam int PW        = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int WORK_BITS = COUNT_BITS + $clog2(PROCESSES + 1);

  func_t                  func_q;
  logic [PID_W-1:0]       pid_q;
  logic [COUNT_BITS-1:0]  amt_q   [RESOURCES];
  logic [COUNT_BITS-1:0]  held_q  [RESOURCES];
  logic [COUNT_BITS-1:0]  avail_q [RESOURCES];
  logic [COUNT_BITS-1:0]  alloc_q [PROCESSES][RESOURCES];
  logic [COUNT_BITS-1:0]  need_q  [PROCESSES][RESOURCES];
  logic [WORK_BITS-1:0]   work_q  [RESOURCES];
  logic [PROCESSES-1:0]   done_q;
  logic [PW-1:0]          ptr_q;
  logic                   prog_q;

  logic [4:0]             pid_wide;
  logic                   pid_ok;
  logic [PW-1:0]          pid_idx;
  logic [PW-1:0]          rd_addr;
  logic                   fits;
  logic                   take;
  logic                   last_row;
  logic [PROCESSES-1:0]   done_next;
  logic                   prog_next;
  logic                   row_bad;
  logic                   over_need;
  logic                   short_avail;

  assign pid_wide = 5'(pid_q);
  assign pid_ok   = pid_wide < 5'(PROCESSES);
  assign pid_idx  = pid_ok ? pid_wide[PW-1:0] : '0;
  assign rd_addr  = cmd.chk_step ? ptr_q : pid_idx;

  always_comb begin
    fits        = 1'b1;
    row_bad     = 1'b0;
    over_need   = 1'b0;
    short_avail = 1'b0;
    for (int r = 0; r < RESOURCES; r++) begin
      if (WORK_BITS'(need_q[rd_addr][r]) > work_q[r]) fits = 1'b0;
      if (held_q[r] > amt_q[r]) row_bad = 1'b1;
      if (amt_q[r] > need_q[rd_addr][r]) over_need = 1'b1;
      if (amt_q[r] > avail_q[r]) short_avail = 1'b1;
    end
  end

  assign take      = !done_q[ptr_q] && fits;
  assign last_row  = ptr_q == PW'(PROCESSES - 1);
  assign done_next = done_q | (take ? (PROCESSES'(1) << ptr_q) : '0);
  assign prog_next = prog_q | take;

  assign sts.func        = func_q;
  assign sts.pid_bad     = !pid_ok;
  assign sts.row_bad     = row_bad;
  assign sts.over_need   = over_need;
  assign sts.short_avail = short_avail;
  assign sts.chk_end     = last_row && (!prog_next || (&done_next));
  assign sts.chk_safe    = &done_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= func;
      pid_q  <= proc_id;
      for (int r = 0; r < RESOURCES; r++) begin
        amt_q[r]  <= COUNT_BITS'(amount[r]);
        held_q[r] <= COUNT_BITS'(held[r]);
      end
    end
    if (cmd.chk_init) begin
      for (int r = 0; r < RESOURCES; r++) work_q[r] <= WORK_BITS'(avail_q[r]);
    end else if (cmd.chk_step && take) begin
      for (int r = 0; r < RESOURCES; r++)
        work_q[r] <= work_q[r] + WORK_BITS'(alloc_q[ptr_q][r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_q <= '0;
      ptr_q  <= '0;
      prog_q <= 1'b0;
      for (int r = 0; r < RESOURCES; r++) avail_q[r] <= '0;
      for (int p = 0; p < PROCESSES; p++) begin
        for (int r = 0; r < RESOURCES; r++) begin
          alloc_q[p][r] <= '0;
          need_q[p][r]  <= '0;
        end
      end
    end else begin
      if (cmd.chk_init) begin
        done_q <= '0;
        ptr_q  <= '0;
        prog_q <= 1'b0;
      end else if (cmd.chk_step) begin
        done_q <= done_next;
        if (last_row) begin
          ptr_q  <= '0;
          prog_q <= 1'b0;
        end else begin
          ptr_q  <= ptr_q + PW'(1);
          prog_q <= prog_next;
        end
      end
      for (int r = 0; r < RESOURCES; r++) begin
        if (cmd.wr_avail) avail_q[r] <= amt_q[r];
        else if (cmd.grant) avail_q[r] <= avail_q[r] - amt_q[r];
        else if (cmd.undo) avail_q[r] <= avail_q[r] + amt_q[r];
        if (cmd.wr_row) begin
          alloc_q[pid_idx][r] <= held_q[r];
          need_q[pid_idx][r]  <= amt_q[r] - held_q[r];
        end else if (cmd.grant) begin
          alloc_q[pid_idx][r] <= alloc_q[pid_idx][r] + amt_q[r];
          need_q[pid_idx][r]  <= need_q[pid_idx][r] - amt_q[r];
        end else if (cmd.undo) begin
          alloc_q[pid_idx][r] <= alloc_q[pid_idx][r] - amt_q[r];
          need_q[pid_idx][r]  <= need_q[pid_idx][r] + amt_q[r];
        end
      end
    end
  end

endmodule

// ===== rtl/bankers_safety_allocator.sv =====
// Banker's safety allocator: top level joining controller and datapath.
// Depends on bsa_pkg, bsa_ctrl and bsa_dpath.
//
// Usage: one command beat enters on the s_ group, one result beat leaves on
// the m_ group for every command. s_tuser carries the function code; s_tdata
// carries the process index and the per-resource amounts and holdings.
// The block takes one command at a time: s_tready is high only while idle.
// After decode, the safety scan makes one or more passes over the process
// table; a request whose tentative grant is unsafe is rolled back and the
// table is scanned again. The scan compares one process row per cycle
// against the work vector, and the block takes no new command before the
// result of the last one has gone into the output register.
// The result sits in an output register; while the receiver stalls it holds
// there and the next command is still accepted, with its result held back
// until the register frees. Reset clears the available vector and the
// allocation and need tables to zero and drops any pending result.
module bankers_safety_allocator #(
  parameter int PROCESSES  = 8,
  parameter int RESOURCES  = 4,
  parameter int COUNT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // func
  input  logic [71:0] s_tdata,   // proc_id, amount_0..3, held_0..3, zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // status, is_safe, zero fill
);
  import bsa_pkg::*;

  cmd_t                              cmd;
  sts_t                              sts;
  status_t                           out_status;
  logic                              out_safe;
  func_t                             func;
  logic [PID_W-1:0]                  proc_id;
  logic [IN_LANES-1:0][AMT_W-1:0]    amount;
  logic [IN_LANES-1:0][AMT_W-1:0]    held;

  assign func    = func_t'(s_tuser);
  assign proc_id = s_tdata[PID_W-1:0];

  always_comb begin
    for (int k = 0; k < IN_LANES; k++) begin
      amount[k] = s_tdata[PID_W + AMT_W*k +: AMT_W];
      held[k]   = s_tdata[PID_W + AMT_W*(IN_LANES + k) +: AMT_W];
    end
  end

  assign m_tdata = {4'b0000, out_safe, out_status};

  bsa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .out_status (out_status),
    .out_safe   (out_safe),
    .cmd        (cmd),
    .sts        (sts)
  );

  bsa_dpath #(
    .PROCESSES  (PROCESSES),
    .RESOURCES  (RESOURCES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .func    (func),
    .proc_id (proc_id),
    .amount  (amount),
    .held    (held),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule

// ===== rtl/bsa_checker.sv =====
// Port-level checker for the Banker's safety allocator, bound to the top.
// Depends on bsa_pkg and bankers_safety_allocator_defines.svh.
`include "bankers_safety_allocator_defines.svh"

module bsa_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);
  import bsa_pkg::*;

  `BSA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  `BSA_ASSERT_NOW(a_status_range, m_tvalid, m_tdata[2:0] <= ST_UNSAFE, "status code out of range")
  `BSA_ASSERT_NOW(a_unsafe_flag, m_tvalid && m_tdata[2:0] == ST_UNSAFE, !m_tdata[3], "unsafe status with safe flag")
  `BSA_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second command taken while busy")
  `BSA_ASSERT_NEXT(a_no_early_out, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "result before decode")

endmodule

bind bankers_safety_allocator bsa_checker u_bsa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
